// ----- hw/rtl/rgbc_pkg.sv -----
// shared types and constants for the rgbc to hsl converter
package rgbc_pkg;

   // stage indexes of the conversion pipeline
   localparam int unsigned NUM_STAGES    = 20;
   localparam int unsigned STAGE_W       = 5;
   localparam int unsigned S_LOAD        = 0;
   localparam int unsigned S_OVF         = 1;
   localparam int unsigned S_PDIV_FIRST  = 2;
   localparam int unsigned S_PDIV_LAST   = 8;
   localparam int unsigned S_PCT         = 9;
   localparam int unsigned S_MNX         = 10;
   localparam int unsigned S_PREP        = 11;
   localparam int unsigned S_HDIV_FIRST  = 12;
   localparam int unsigned S_HDIV_LAST   = 18;
   localparam int unsigned S_OUT         = 19;

   // channel order inside packed per-channel arrays
   localparam int unsigned CH_RED        = 0;
   localparam int unsigned CH_GREEN      = 1;
   localparam int unsigned CH_BLUE       = 2;

   // stream widths
   localparam int unsigned REQ_DATA_W    = 64;
   localparam int unsigned RSP_DATA_W    = 24;

   // constants of the conversion
   localparam logic [6:0]  PCT_FULL      = 7'd100;
   localparam logic [6:0]  HALF_LIGHT    = 7'd50;
   localparam logic [7:0]  SUM_FULL      = 8'd200;
   localparam logic [8:0]  HUE_GREEN     = 9'd120;
   localparam logic [8:0]  HUE_BLUE      = 9'd240;
   localparam logic [8:0]  HUE_WRAP      = 9'd360;
   localparam logic [6:0]  DEG_SECTOR    = 7'd60;

   // which channel holds the maximum
   typedef enum logic [1:0] {
      SEL_RED,
      SEL_GREEN,
      SEL_BLUE
   } sel_type;

   // everything one item carries down the pipeline
   typedef struct packed {
      logic              err;
      logic [2:0][22:0]  rem;
      logic [15:0]       den;
      logic [2:0][6:0]   quo;
      logic [2:0]        ovf;
      logic [2:0][6:0]   pct;
      logic [6:0]        mx;
      logic [6:0]        mn;
      logic [6:0]        dif;
      logic [7:0]        sum;
      logic [6:0]        light;
      sel_type           sel;
      logic              neg;
      logic              gray;
      logic [12:0]       hrem;
      logic [5:0]        hquo;
      logic [13:0]       srem;
      logic [7:0]        sden;
      logic [6:0]        squo;
      logic [8:0]        hue;
      logic [6:0]        sat;
   } item_type;

endpackage

// ----- hw/rtl/rgbc_to_hsl_converter_top.sv -----
// top level of the rgbc to hsl converter: a 20 stage conversion pipeline
//
// channel   direction  handshake              payload
// req_      in         req_tvalid/req_tready  req_tdata: red, green, blue, clear counts
// rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata: hue, saturation, lightness, error
//
// one transfer is taken every cycle while the pipeline is not stalled by rsp_tready low
// most stages hold the restoring dividers, one quotient bit per stage:
//   7 stages for the three channel percentages, 7 for hue and saturation
// reset clears the valid bits only; payload registers are not reset
// each stage holds its item while the next one is full and stalled, so
// bubbles close up under rsp_tready low and nothing is dropped or repeated
module rgbc_to_hsl_converter_top
   import rgbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] red_count, [31:16] green_count, [47:32] blue_count, [63:48] clear_count
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [8:0] hue, [15:9] saturation, [22:16] lightness, [23] divide_error
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   item_type               pipe_ff [NUM_STAGES];
   item_type               pipe_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]  valid_ff;
   logic [NUM_STAGES-1:0]  stage_rdy;

   // per-stage work; idx is a constant in every unrolled copy
   function automatic item_type stage_fn(input logic [STAGE_W-1:0] idx, input item_type d);
      item_type   o;
      int unsigned k;
      logic [22:0] psh;
      logic [12:0] hsh;
      logic [13:0] ssh;
      logic [6:0]  ox;
      logic [6:0]  oy;
      logic [6:0]  mag;
      logic [8:0]  q;
      o   = d;
      k   = 0;
      psh = '0;
      hsh = '0;
      ssh = '0;
      ox  = '0;
      oy  = '0;
      mag = '0;
      q   = '0;
      if (idx == STAGE_W'(S_OVF)) begin
         // quotient would not fit in 7 bits: percentage saturates anyway
         for (int c = 0; c < 3; c++) begin
            o.ovf[c] = {1'b0, d.rem[c]} >= {1'b0, d.den, 7'b0};
         end
      end else if (idx >= STAGE_W'(S_PDIV_FIRST) && idx <= STAGE_W'(S_PDIV_LAST)) begin
         k   = S_PDIV_LAST - 32'(idx);
         psh = {7'b0, d.den} << k;
         for (int c = 0; c < 3; c++) begin
            if (!d.ovf[c] && d.rem[c] >= psh) begin
               o.rem[c]    = d.rem[c] - psh;
               o.quo[c][k] = 1'b1;
            end
         end
      end else if (idx == STAGE_W'(S_PCT)) begin
         for (int c = 0; c < 3; c++) begin
            o.pct[c] = (d.ovf[c] || d.quo[c] > PCT_FULL) ? PCT_FULL : d.quo[c];
         end
      end else if (idx == STAGE_W'(S_MNX)) begin
         // ties: red over green over blue
         if (d.pct[CH_RED] >= d.pct[CH_GREEN] && d.pct[CH_RED] >= d.pct[CH_BLUE]) begin
            o.sel = SEL_RED;
            o.mx  = d.pct[CH_RED];
         end else if (d.pct[CH_GREEN] >= d.pct[CH_BLUE]) begin
            o.sel = SEL_GREEN;
            o.mx  = d.pct[CH_GREEN];
         end else begin
            o.sel = SEL_BLUE;
            o.mx  = d.pct[CH_BLUE];
         end
         o.mn = d.pct[CH_RED];
         if (d.pct[CH_GREEN] < o.mn) o.mn = d.pct[CH_GREEN];
         if (d.pct[CH_BLUE] < o.mn) o.mn = d.pct[CH_BLUE];
         o.dif   = o.mx - o.mn;
         o.sum   = {1'b0, o.mx} + {1'b0, o.mn};
         o.light = o.sum[7:1];
      end else if (idx == STAGE_W'(S_PREP)) begin
         case (d.sel)
            SEL_RED: begin
               ox = d.pct[CH_GREEN];
               oy = d.pct[CH_BLUE];
            end
            SEL_GREEN: begin
               ox = d.pct[CH_BLUE];
               oy = d.pct[CH_RED];
            end
            SEL_BLUE: begin
               ox = d.pct[CH_RED];
               oy = d.pct[CH_GREEN];
            end
            default: begin
               ox = '0;
               oy = '0;
            end
         endcase
         o.neg  = ox < oy;
         mag    = o.neg ? (oy - ox) : (ox - oy);
         o.gray = d.dif == '0;
         o.hrem = 13'(mag * DEG_SECTOR);
         o.srem = 14'(d.dif * PCT_FULL);
         o.sden = (d.light <= HALF_LIGHT) ? d.sum : (SUM_FULL - d.sum);
         o.hquo = '0;
         o.squo = '0;
      end else if (idx >= STAGE_W'(S_HDIV_FIRST) && idx <= STAGE_W'(S_HDIV_LAST)) begin
         k = S_HDIV_LAST - 32'(idx);
         // hue quotient stays below 64, so its top step is skipped
         if (k < 6) begin
            hsh = {6'b0, d.dif} << k;
            if (d.hrem >= hsh) begin
               o.hrem    = d.hrem - hsh;
               o.hquo[k] = 1'b1;
            end
         end
         ssh = {6'b0, d.sden} << k;
         if (d.srem >= ssh) begin
            o.srem    = d.srem - ssh;
            o.squo[k] = 1'b1;
         end
      end else if (idx == STAGE_W'(S_OUT)) begin
         q = {3'b0, d.hquo};
         case (d.sel)
            SEL_RED:   o.hue = d.neg ? (HUE_WRAP - q) : q;
            SEL_GREEN: o.hue = d.neg ? (HUE_GREEN - q) : (HUE_GREEN + q);
            SEL_BLUE:  o.hue = d.neg ? (HUE_BLUE - q) : (HUE_BLUE + q);
            default:   o.hue = '0;
         endcase
         o.sat = d.squo;
         if (d.gray) begin
            o.hue = '0;
            o.sat = '0;
         end
         if (d.err) begin
            o.hue   = '0;
            o.sat   = '0;
            o.light = '0;
         end
      end
      return o;
   endfunction

   // a stage may load when it is empty or its item moves on
   always_comb begin
      stage_rdy[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_rdy[i] = !valid_ff[i] || stage_rdy[i+1];
      end
   end

   // stage 0: flag a zero clear count and scale each count by 100 ahead of the percentage divide
   always_comb begin
      pipe_in[S_LOAD]      = '0;
      pipe_in[S_LOAD].err  = req_tdata[63:48] == '0;
      pipe_in[S_LOAD].den  = req_tdata[63:48];
      pipe_in[S_LOAD].rem[CH_RED]   = 23'(req_tdata[15:0] * PCT_FULL);
      pipe_in[S_LOAD].rem[CH_GREEN] = 23'(req_tdata[31:16] * PCT_FULL);
      pipe_in[S_LOAD].rem[CH_BLUE]  = 23'(req_tdata[47:32] * PCT_FULL);
      for (int i = 1; i < NUM_STAGES; i++) begin
         pipe_in[i] = stage_fn(STAGE_W'(i), pipe_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_rdy[0]) valid_ff[0] <= req_tvalid;
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_rdy[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // payload moves with its valid bit, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (stage_rdy[i]) pipe_ff[i] <= pipe_in[i];
      end
   end

   assign req_tready = stage_rdy[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = {pipe_ff[S_OUT].err, pipe_ff[S_OUT].light,
                        pipe_ff[S_OUT].sat, pipe_ff[S_OUT].hue};

endmodule

// ----- hw/rtl/rgbc_checker.sv -----
// port-level checks for the rgbc to hsl converter, bound to the top level
module rgbc_checker
   import rgbc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // divide error forces every other field to zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23] |-> rsp_tdata[22:0] == '0)
      else $error("fields not zero on divide error");

   // fields stay in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:0] <= HUE_WRAP && rsp_tdata[15:9] <= PCT_FULL
                     && rsp_tdata[22:16] <= PCT_FULL)
      else $error("result field out of range");

endmodule

bind rgbc_to_hsl_converter_top rgbc_checker u_rgbc_checker (.*);

// ----- tb/rgbc_to_hsl_converter_top_tb.sv -----
// self-checking testbench for the rgbc to hsl converter pipeline
module rgbc_to_hsl_converter_top_tb
   import rgbc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // one expected conversion result
   typedef struct packed {
      logic [8:0] hue;
      logic [6:0] sat;
      logic [6:0] light;
      logic       err;
   } hsl_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [15:0] red, [31:16] green, [47:32] blue, [63:48] clear
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [8:0] hue, [15:9] saturation, [22:16] lightness, [23] divide_error
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [63:0] pending_readings[$];
   hsl_type     expected_hsl[$];
   int          fail_count = 0;
   bit          stim_done = 1'b0;
   bit          quiet = 1'b0;   // no idling in the last part of the run
   int          send_gap = 0;
   int          recv_gap = 0;

   rgbc_to_hsl_converter_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // saturating percentage of clear
   function automatic int pct(int cnt, int clr);
      int p;
      p = (cnt * 100) / clr;
      return (p > 100) ? 100 : p;
   endfunction

   // integer hsl conversion of one reading
   function automatic hsl_type convert_reading(logic [63:0] rd);
      hsl_type o;
      int r, g, b, mx, mn, dif, sum, h, s, l, clr;
      o = '0;
      clr = rd[63:48];
      if (clr == 0) begin
         o.err = 1'b1;
         return o;
      end
      r = pct(rd[15:0], clr);
      g = pct(rd[31:16], clr);
      b = pct(rd[47:32], clr);
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      dif = mx - mn;
      sum = mx + mn;
      l = sum / 2;
      h = 0;
      s = 0;
      if (dif != 0) begin
         // sv int division truncates toward zero like c
         if (mx == r) begin
            h = (60 * (g - b)) / dif;
            if (g < b) h += 360;
         end else if (mx == g) begin
            h = (60 * (b - r)) / dif + 120;
         end else begin
            h = (60 * (r - g)) / dif + 240;
         end
         if (l <= 50) s = (dif * 100) / sum;
         else s = (dif * 100) / (200 - sum);
      end
      o.hue = h[8:0];
      o.sat = s[6:0];
      o.light = l[6:0];
      return o;
   endfunction

   function automatic logic [63:0] pack_reading(int r, int g, int b, int c);
      return {c[15:0], b[15:0], g[15:0], r[15:0]};
   endfunction

   // random count: mostly scaled to clear so percentages spread, some raw
   function automatic int rand_count(int clr);
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 65535);
         1: return $urandom_range(0, clr);
         default: return (clr * $urandom_range(0, 110)) / 100;
      endcase
   endfunction

   // driver: new transfer or idle burst after every accepted transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_readings.size() > 0) begin
               req_tdata <= pending_readings[0];
               expected_hsl.push_back(convert_reading(pending_readings[0]));
               void'(pending_readings.pop_front());
               req_tvalid <= 1'b1;
               if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 18);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each transfer with the oldest expectation, stall in bursts
   always @(posedge clock) begin
      hsl_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[8:0], rsp_tdata[15:9], rsp_tdata[22:16], rsp_tdata[23]};
            if (expected_hsl.size() == 0) begin
               $display("%0t unexpected result actual %h", $time, got);
               fail_count++;
            end else begin
               want = expected_hsl.pop_front();
               if (got.hue !== want.hue)
                  $display("%0t hue expected %0d actual %0d", $time, want.hue, got.hue);
               if (got.sat !== want.sat)
                  $display("%0t saturation expected %0d actual %0d", $time, want.sat, got.sat);
               if (got.light !== want.light)
                  $display("%0t lightness expected %0d actual %0d", $time,
                           want.light, got.light);
               if (got.err !== want.err)
                  $display("%0t divide_error expected %0d actual %0d", $time,
                           want.err, got.err);
               if (got !== want) fail_count++;
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 17);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int c, wait_cycles;
      // directed: extremes, zero clear, gray, hue wrap, ties, both saturation branches
      pending_readings.push_back(pack_reading(0, 0, 0, 0));
      pending_readings.push_back(pack_reading(65535, 65535, 65535, 0));
      pending_readings.push_back(pack_reading(65535, 65535, 65535, 65535));
      pending_readings.push_back(pack_reading(0, 0, 0, 65535));
      pending_readings.push_back(pack_reading(65535, 0, 0, 1));
      pending_readings.push_back(pack_reading(50, 50, 50, 100));
      pending_readings.push_back(pack_reading(100, 0, 1, 100));
      pending_readings.push_back(pack_reading(100, 0, 99, 100));
      pending_readings.push_back(pack_reading(100, 100, 0, 100));
      pending_readings.push_back(pack_reading(100, 0, 100, 100));
      pending_readings.push_back(pack_reading(0, 100, 100, 100));
      pending_readings.push_back(pack_reading(20, 80, 10, 100));
      pending_readings.push_back(pack_reading(10, 30, 90, 100));
      pending_readings.push_back(pack_reading(90, 60, 70, 100));
      pending_readings.push_back(pack_reading(30, 20, 10, 100));
      pending_readings.push_back(pack_reading(300, 10, 5, 200));
      pending_readings.push_back(pack_reading(43690, 21845, 65535, 65535));
      pending_readings.push_back(pack_reading(21845, 43690, 1, 43690));
      pending_readings.push_back(pack_reading(1, 2, 3, 3));
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 1000; i++) begin
         case ($urandom_range(0, 9))
            0: c = 0;
            1: c = $urandom_range(1, 65535);
            2: c = $urandom_range(1, 300);
            default: c = $urandom_range(1, 65535) >> $urandom_range(0, 12);
         endcase
         if (c == 0 && $urandom_range(0, 1)) c = 1;
         pending_readings.push_back(pack_reading(rand_count(c), rand_count(c),
                                                 rand_count(c), c));
         if (i == 800) begin
            // last stretch runs back to back
            while (pending_readings.size() > 100) @(posedge clock);
            quiet = 1'b1;
         end
      end
      while (pending_readings.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_hsl.size() > 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < 2 * NUM_STAGES) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (fail_count == 0 && expected_hsl.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule

// ----- filelist.f -----
hw/rtl/rgbc_pkg.sv
hw/rtl/rgbc_to_hsl_converter_top.sv
hw/rtl/rgbc_checker.sv
tb/rgbc_to_hsl_converter_top_tb.sv
